[rtl/core/oate_pkg.sv]
// Shared types and constants for the ordered array table engine.
package oate_pkg;

   localparam int OP_W      = 3;
   localparam int POS_W     = 7;
   localparam int VAL_W     = 32;
   localparam int CAP_W     = 7;
   localparam int STATUS_W  = 3;
   localparam int COUNT_W   = 7;
   localparam int FOUND_W   = 6;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_EDIT   = 3'd2,
      OP_DELETE = 3'd3,
      OP_READ   = 3'd4,
      OP_FIND   = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_INDEX = 3'd1,
      ST_FULL      = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      RD_ZERO = 2'd0,
      RD_MEM  = 2'd1,
      RD_ONES = 2'd2
   } rd_sel_type;

   typedef enum logic [3:0] {
      ACT_NONE       = 4'd0,
      ACT_APPEND     = 4'd1,
      ACT_EDIT       = 4'd2,
      ACT_READ       = 4'd3,
      ACT_INS_START  = 4'd4,
      ACT_INS_STEP   = 4'd5,
      ACT_DEL_START  = 4'd6,
      ACT_DEL_STEP   = 4'd7,
      ACT_FIND_START = 4'd8,
      ACT_FIND_STEP  = 4'd9
   } act_type;

   typedef struct packed {
      logic       load;
      act_type    act;
      logic       respond;
      status_type status;
      rd_sel_type rd_sel;
   } dp_cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   pos_above_count;
      logic   pos_not_below_count;
      logic   ins_done;
      logic   walk_end;
      logic   hit;
   } dp_stat_type;

endpackage

[rtl/core/ordered_array_table_engine_core.sv]
// Top level of the ordered array table engine: controller plus datapath.
//
//  channel   ports                                   handshake
//  request   req_operation, req_position, req_value  start && !busy
//  result    rsp_status ... rsp_is_full              rsp_valid, one cycle
//  config    csr_wr_data (capacity in use)           csr_wr_en
//
// Append, edit, read and refused requests pass from the decide state straight to the respond state.
// Insert/delete walk the entries behind the position when one moves (one RAM move per cycle);
// find walks from index 0 to the first match, or up to the count on a miss.
// busy drops in the strobe cycle; the next request can be taken at the edge ending it.
// Synchronous reset clears count and sets capacity to 64; entries need no clearing.
// The receiver cannot stall; each result is valid for exactly one cycle.
module ordered_array_table_engine_core
   import oate_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [OP_W-1:0]         req_operation,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    csr_wr_en,
   input  logic [CAP_W-1:0]        csr_wr_data,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic [FOUND_W-1:0]      rsp_found_position,
   output logic [COUNT_W-1:0]      rsp_entry_count,
   output logic                    rsp_is_empty,
   output logic                    rsp_is_full
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   oate_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   oate_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_operation      (req_operation),
      .req_position       (req_position),
      .req_value          (req_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_read_value     (rsp_read_value),
      .rsp_found_position (rsp_found_position),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_is_full        (rsp_is_full)
   );

endmodule

[rtl/core/oate_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module oate_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/oate_ctrl.sv]
// Controller state machine: decodes the request and sequences the datapath.
module oate_ctrl
   import oate_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_DECIDE  = 6'b000010,
      S_INSERT  = 6'b000100,
      S_DELETE  = 6'b001000,
      S_FIND    = 6'b010000,
      S_RESPOND = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   rd_sel_type rsel_ff, rsel_in;

   always_comb begin
      state_in    = state_ff;
      status_in   = status_ff;
      rsel_in     = rsel_ff;
      cmd.load    = 1'b0;
      cmd.act     = ACT_NONE;
      cmd.respond = 1'b0;
      cmd.status  = status_ff;
      cmd.rd_sel  = rsel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load  = 1'b1;
               status_in = ST_OK;
               rsel_in   = RD_ZERO;
               state_in  = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_RESPOND;
            unique case (stat.op)
               OP_APPEND: begin
                  if (stat.full) status_in = ST_FULL;
                  else cmd.act = ACT_APPEND;
               end
               OP_INSERT: begin
                  if (stat.full) begin
                     status_in = ST_FULL;
                  end else if (stat.pos_above_count) begin
                     status_in = ST_BAD_INDEX;
                  end else begin
                     cmd.act  = ACT_INS_START;
                     state_in = S_INSERT;
                  end
               end
               OP_EDIT: begin
                  if (stat.pos_not_below_count) status_in = ST_BAD_INDEX;
                  else cmd.act = ACT_EDIT;
               end
               OP_DELETE: begin
                  if (stat.empty) begin
                     status_in = ST_EMPTY;
                  end else if (stat.pos_not_below_count) begin
                     status_in = ST_BAD_INDEX;
                  end else begin
                     cmd.act  = ACT_DEL_START;
                     state_in = S_DELETE;
                  end
               end
               OP_READ: begin
                  if (stat.pos_not_below_count) begin
                     status_in = ST_BAD_INDEX;
                     rsel_in   = RD_ONES;
                  end else begin
                     cmd.act = ACT_READ;
                     rsel_in = RD_MEM;
                  end
               end
               OP_FIND: begin
                  if (stat.empty) begin
                     status_in = ST_EMPTY;
                  end else begin
                     cmd.act  = ACT_FIND_START;
                     state_in = S_FIND;
                  end
               end
               default: begin
                  // spare opcodes: no change, status ok
               end
            endcase
         end
         S_INSERT: begin
            cmd.act = ACT_INS_STEP;
            if (stat.ins_done) state_in = S_RESPOND;
         end
         S_DELETE: begin
            cmd.act = ACT_DEL_STEP;
            if (stat.walk_end) state_in = S_RESPOND;
         end
         S_FIND: begin
            cmd.act = ACT_FIND_STEP;
            if (stat.hit) begin
               state_in = S_RESPOND;
            end else if (stat.walk_end) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESPOND;
            end
         end
         S_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= ST_OK;
         rsel_ff   <= RD_ZERO;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         rsel_ff   <= rsel_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

[rtl/core/oate_dp.sv]
// Datapath: request and count registers, entry RAM, walk pointer and result registers.
module oate_dp
   import oate_pkg::*;
#(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_stat_type             stat,
   input  logic [OP_W-1:0]         req_operation,
   input  logic [POS_W-1:0]        req_position,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic                    csr_wr_en,
   input  logic [CAP_W-1:0]        csr_wr_data,
   output logic                    rsp_valid,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic signed [VAL_W-1:0] rsp_read_value,
   output logic [FOUND_W-1:0]      rsp_found_position,
   output logic [COUNT_W-1:0]      rsp_entry_count,
   output logic                    rsp_is_empty,
   output logic                    rsp_is_full
);

   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int XW = (CW > POS_W) ? CW : POS_W;
   localparam logic [XW-1:0] MAX_X = XW'(MAX_ENTRIES);

   op_type             op_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [VAL_W-1:0]   val_ff;
   logic [CAP_W-1:0]   cap_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      ptr_ff, ptr_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_addr_ff, pend_addr_in;
   logic [AW-1:0]      found_ff, found_in;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [VAL_W-1:0]   rsp_read_value_ff;
   logic [FOUND_W-1:0] rsp_found_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_empty_ff;
   logic               rsp_full_ff;

   logic [XW-1:0]      count_x, pos_x, ptr_x, cap_x, found_x;
   logic [CW-1:0]      ptr_m1;
   logic               full;

   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [VAL_W-1:0]   wr_data, rd_data;

   assign count_x = XW'(count_ff);
   assign pos_x   = XW'(pos_ff);
   assign ptr_x   = XW'(ptr_ff);
   assign cap_x   = XW'(cap_ff);
   assign found_x = XW'(found_ff);
   assign ptr_m1  = ptr_ff - 1'b1;
   // capacity above the built depth acts as the built depth
   assign full    = (count_x >= cap_x) || (count_x >= MAX_X);

   assign stat.op                  = op_ff;
   assign stat.full                = full;
   assign stat.empty               = (count_ff == '0);
   assign stat.pos_above_count     = (pos_x > count_x);
   assign stat.pos_not_below_count = (pos_x >= count_x);
   assign stat.ins_done            = (ptr_x == pos_x) && !pend_ff;
   assign stat.walk_end            = (ptr_x >= count_x) && !pend_ff;
   assign stat.hit                 = pend_ff && (rd_data == val_ff);

   // Insert and delete walks overlap the read of one entry with the write of the one read before.
   always_comb begin
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      found_in     = found_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[AW-1:0];
      if (cmd.load) found_in = '0;
      case (cmd.act)
         ACT_APPEND: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[AW-1:0];
            wr_data  = val_ff;
            count_in = count_ff + 1'b1;
         end
         ACT_EDIT: begin
            wr_en   = 1'b1;
            wr_addr = pos_x[AW-1:0];
            wr_data = val_ff;
         end
         ACT_READ: begin
            rd_en   = 1'b1;
            rd_addr = pos_x[AW-1:0];
         end
         ACT_INS_START: begin
            ptr_in  = count_ff;
            pend_in = 1'b0;
         end
         ACT_INS_STEP: begin
            if (pend_ff) wr_en = 1'b1;
            if (ptr_x > pos_x) begin
               rd_en        = 1'b1;
               rd_addr      = ptr_m1[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff[AW-1:0];
               ptr_in       = ptr_m1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = pos_x[AW-1:0];
               wr_data  = val_ff;
               count_in = count_ff + 1'b1;
            end
         end
         ACT_DEL_START: begin
            ptr_in  = pos_x[CW-1:0] + 1'b1;
            pend_in = 1'b0;
         end
         ACT_DEL_STEP: begin
            if (pend_ff) wr_en = 1'b1;
            if (ptr_x < count_x) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = ptr_m1[AW-1:0];
               ptr_in       = ptr_ff + 1'b1;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ACT_FIND_START: begin
            ptr_in  = '0;
            pend_in = 1'b0;
         end
         ACT_FIND_STEP: begin
            if (stat.hit) begin
               found_in = pend_addr_ff;
               pend_in  = 1'b0;
            end else if (ptr_x < count_x) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff[AW-1:0];
               ptr_in       = ptr_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   oate_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= cmd.respond;
         if (csr_wr_en) cap_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      pend_addr_ff <= pend_addr_in;
      found_ff     <= found_in;
      if (cmd.load) begin
         op_ff  <= op_type'(req_operation);
         pos_ff <= req_position;
         val_ff <= req_value;
      end
      if (cmd.respond) begin
         rsp_status_ff <= cmd.status;
         case (cmd.rd_sel)
            RD_MEM:  rsp_read_value_ff <= rd_data;
            RD_ONES: rsp_read_value_ff <= '1;
            default: rsp_read_value_ff <= '0;
         endcase
         rsp_found_ff <= found_x[FOUND_W-1:0];
         rsp_count_ff <= count_x[COUNT_W-1:0];
         rsp_empty_ff <= (count_ff == '0);
         rsp_full_ff  <= full;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_value     = rsp_read_value_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_is_empty       = rsp_empty_ff;
   assign rsp_is_full        = rsp_full_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_x <= MAX_X)
      else $error("entry count above built depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + 1'b1) || (count_ff == $past(count_ff) - 1'b1))
      else $error("entry count moved by more than one");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (XW'(wr_addr) < MAX_X))
      else $error("RAM write beyond built depth");

   a_pend_walk: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (cmd.act == ACT_INS_STEP) || (cmd.act == ACT_DEL_STEP)
                  || (cmd.act == ACT_FIND_STEP))
      else $error("pending RAM data outside a walk");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

endmodule
